[rtl/core/dkcm_pkg.sv]
package dkcm_pkg;

    // Model geometry.
    localparam int MAX_ORDER   = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int CTX_W       = 2 * MAX_ORDER;
    localparam int NUM_CTX     = 1 << CTX_W;
    localparam int ROW_W       = 4 * COUNT_WIDTH;
    localparam int NEXT_W      = COUNT_WIDTH + 1;

    // Register and field widths.
    localparam int ORDER_W  = 4;
    localparam int ALPHA_W  = 10;
    localparam int MAXC_W   = 16;
    localparam int CMP_W    = (NEXT_W > MAXC_W) ? NEXT_W : MAXC_W;
    localparam int PROD_W   = ALPHA_W + COUNT_WIDTH;
    localparam int FSUM_W   = PROD_W + 3;
    localparam int FREQ_W   = 26;
    localparam int TOTAL_W  = 28;
    localparam int SYM_W    = 2;
    localparam int STATUS_W = 2;

    // Port widths.
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = ((4 * FREQ_W + TOTAL_W + SYM_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Output queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CNT_W = 3;

    // Register reset values.
    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(8);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(1);
    localparam logic [MAXC_W-1:0]  MAXC_RESET  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER = 2'd0,
        CFG_ALPHA = 2'd1,
        CFG_MAXC  = 2'd2
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_UNIQUE = 2'd0,
        STATUS_TIE    = 2'd1,
        STATUS_UNSEEN = 2'd2
    } status_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef count_t [3:0] row_t;

    // One result item; freq[0] sits in the lowest bits.
    typedef struct packed {
        status_t                   status;
        logic [SYM_W-1:0]          best;
        logic [TOTAL_W-1:0]        total;
        logic [3:0][FREQ_W-1:0]    freq;
    } result_t;

    // Context mask for an order, clamped to the range 1 to MAX_ORDER.
    function automatic logic [CTX_W-1:0] ctx_mask(input logic [ORDER_W-1:0] order);
        logic [CTX_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_ORDER; i++) begin
            if (i < int'(order) || i == 0) begin
                m[2*i +: 2] = 2'b11;
            end
        end
        return m;
    endfunction

endpackage

[rtl/core/dna_order_k_context_counter_model_unit.sv]
// Order-k context model for a nucleotide stream.
// Input channel (s_): one symbol per transfer, with s_tuser set to restart the
// context at zero before that symbol. Result channel (m_): one transfer per
// input symbol, in order, carrying the four frequencies 1 + alpha * count of
// the current context, their sum and the most likely symbol, with m_tuser
// telling whether that symbol is a unique maximum, a tie, or an unseen context.
// Configuration channel (cfg_): register index and data, always accepted;
// write it only while no symbol is in flight.
// A result passes the memory read, the multiply stage and the output queue
// before it shows on m_. Throughput: one symbol per cycle while s_tready is
// high; the counter row of a context is read, updated and written back by a
// pipelined read-modify-write on one memory, with the write forwarded when
// the next symbol reads the same row.
// Reset: the context index and registers take their defaults, and a clearing
// pass zeroes all 65536 counter rows, one row a cycle; s_tready stays low
// until that pass ends.
// Stall: results wait in a four-entry queue; s_tready drops when the queue and
// the two pipeline stages together hold four items, so nothing is lost.
module dna_order_k_context_counter_model_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [dkcm_pkg::S_TDATA_W-1:0]       s_tdata,   // [1:0] symbol, [7:2] zero
    input  logic                                 s_tuser,   // [0] restart
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [25:0] freq_a, [51:26] freq_c, [77:52] freq_g, [103:78] freq_t,
    // [131:104] freq_total, [133:132] best_symbol, [135:134] zero
    output logic [dkcm_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [dkcm_pkg::STATUS_W-1:0]        m_tuser,   // [1:0] best_status
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dkcm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dkcm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import dkcm_pkg::*;

    logic [ORDER_W-1:0]    order_reg;
    logic [ALPHA_W-1:0]    alpha_reg;
    logic [MAXC_W-1:0]     maxc_reg;

    logic                  clr_active_reg;
    logic [CTX_W-1:0]      clr_addr_reg;

    logic [CTX_W-1:0]      ctx_reg;
    logic [CTX_W-1:0]      ctx_next;
    logic [CTX_W-1:0]      ctx_now;
    logic [CTX_W-1:0]      cur_mask;
    logic [SYM_W-1:0]      in_sym;
    logic                  in_acc;

    logic                  s1_valid_reg;
    logic [CTX_W-1:0]      s1_ctx_reg;
    logic [SYM_W-1:0]      s1_sym_reg;
    logic                  s1_fwd_reg;
    row_t                  fwd_row_reg;
    row_t                  cur_row;
    row_t                  upd_row;
    logic [NEXT_W-1:0]     cnt_next;
    logic                  halve;
    logic [3:0][PROD_W-1:0] prod;

    logic                  s2_valid_reg;
    logic [3:0][PROD_W-1:0] s2_prod_reg;
    logic [3:0][FSUM_W-1:0] freq_full;
    logic [FSUM_W-1:0]     sum_full;
    logic [SYM_W-1:0]      best;
    logic                  tie;
    result_t               s2_res;

    logic                  ram_wr_en;
    logic [CTX_W-1:0]      ram_wr_addr;
    logic [ROW_W-1:0]      ram_wr_data;
    logic [ROW_W-1:0]      ram_rd_data;

    result_t               fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_cnt_reg;
    logic [FIFO_CNT_W:0]   used;
    logic                  pop;
    result_t               head;

    // Configuration registers; the channel never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_RESET;
            alpha_reg <= ALPHA_RESET;
            maxc_reg  <= MAXC_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ORDER: order_reg <= cfg_data[ORDER_W-1:0];
                CFG_ALPHA: alpha_reg <= cfg_data[ALPHA_W-1:0];
                CFG_MAXC:  maxc_reg  <= cfg_data[MAXC_W-1:0];
                default: ;
            endcase
        end
    end

    // Clearing pass over every counter row after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + CTX_W'(1);
            if (clr_addr_reg == '1) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Credit check: the queue must have room for every item in flight.
    always_comb begin
        used = (FIFO_CNT_W+1)'(fifo_cnt_reg) + (FIFO_CNT_W+1)'(s1_valid_reg)
             + (FIFO_CNT_W+1)'(s2_valid_reg);
        s_tready = !clr_active_reg && (used < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    end

    assign in_acc = s_tvalid && s_tready;
    assign in_sym = s_tdata[SYM_W-1:0];

    // Context of the incoming symbol and the context that follows it.
    always_comb begin
        cur_mask = ctx_mask(order_reg);
        ctx_now  = s_tuser ? '0 : (ctx_reg & cur_mask);
        ctx_next = {ctx_now[CTX_W-SYM_W-1:0], in_sym} & cur_mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg <= '0;
        end else if (in_acc) begin
            ctx_reg <= ctx_next;
        end
    end

    // Stage valid flags; the row read is issued at the accepting edge.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // A write at the same edge as the read of the same row is forwarded.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_ctx_reg  <= ctx_now;
            s1_sym_reg  <= in_sym;
            s1_fwd_reg  <= s1_valid_reg && (s1_ctx_reg == ctx_now);
            fwd_row_reg <= upd_row;
        end
    end

    // Counter update with halving, and the four products.
    always_comb begin
        cur_row  = s1_fwd_reg ? fwd_row_reg : row_t'(ram_rd_data);
        cnt_next = NEXT_W'(cur_row[s1_sym_reg]) + NEXT_W'(1);
        halve    = (CMP_W'(cnt_next) >= CMP_W'(maxc_reg)) || cnt_next[COUNT_WIDTH];
        for (int n = 0; n < 4; n++) begin
            if (SYM_W'(n) == s1_sym_reg) begin
                upd_row[n] = halve ? cnt_next[COUNT_WIDTH:1] : cnt_next[COUNT_WIDTH-1:0];
            end else begin
                upd_row[n] = halve ? (cur_row[n] >> 1) : cur_row[n];
            end
            prod[n] = PROD_W'(alpha_reg) * PROD_W'(cur_row[n]);
        end
    end

    // Memory port: clearing pass first, then the row write-back.
    always_comb begin
        ram_wr_en   = clr_active_reg || s1_valid_reg;
        ram_wr_addr = clr_active_reg ? clr_addr_reg : s1_ctx_reg;
        ram_wr_data = clr_active_reg ? '0 : ROW_W'(upd_row);
    end

    dkcm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_CTX)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ctx_now),
        .rd_data (ram_rd_data)
    );

    // Stage two: products registered after the multipliers.
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_prod_reg <= prod;
        end
    end

    // Frequencies, sum and the most likely symbol.
    always_comb begin
        sum_full = '0;
        for (int n = 0; n < 4; n++) begin
            freq_full[n] = FSUM_W'(s2_prod_reg[n]) + FSUM_W'(1);
            sum_full     = sum_full + freq_full[n];
        end
        best = '0;
        for (int n = 1; n < 4; n++) begin
            if (freq_full[n] > freq_full[best]) begin
                best = SYM_W'(n);
            end
        end
        tie = 1'b0;
        for (int n = 0; n < 4; n++) begin
            if (SYM_W'(n) != best && freq_full[n] == freq_full[best]) begin
                tie = 1'b1;
            end
        end
        for (int n = 0; n < 4; n++) begin
            s2_res.freq[n] = freq_full[n][FREQ_W-1:0];
        end
        s2_res.total = sum_full[TOTAL_W-1:0];
        if (sum_full == FSUM_W'(4)) begin
            s2_res.best   = '0;
            s2_res.status = STATUS_UNSEEN;
        end else if (tie) begin
            s2_res.best   = '0;
            s2_res.status = STATUS_TIE;
        end else begin
            s2_res.best   = best;
            s2_res.status = STATUS_UNIQUE;
        end
    end

    // Output queue; the credit check guarantees room for every push.
    assign pop  = m_tvalid && m_tready;
    assign head = fifo_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            fifo_mem_reg[wr_ptr_reg] <= s2_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (s2_valid_reg) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + FIFO_CNT_W'(s2_valid_reg) - FIFO_CNT_W'(pop);
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = M_TDATA_W'({head.best, head.total, head.freq});
    assign m_tuser  = head.status;

endmodule

[rtl/core/dkcm_ram.sv]
module dkcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port; the read port returns the old data on a collision.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/dkcm_checker.sv]
module dkcm_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [dkcm_pkg::S_TDATA_W-1:0]       s_tdata,
    input logic                                 s_tuser,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [dkcm_pkg::M_TDATA_W-1:0]       m_tdata,
    input logic [dkcm_pkg::STATUS_W-1:0]        m_tuser,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [dkcm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input logic [dkcm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import dkcm_pkg::*;

    localparam int BEST_LSB = 4 * FREQ_W + TOTAL_W;

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The clearing pass keeps the input closed after reset.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during counter clearing");

    // Every accepted symbol has a result waiting once it has passed the pipeline.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##3 m_tvalid)
        else $error("no result after an accepted symbol");

    // The best symbol reads zero unless the maximum is unique.
    a_best_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_UNIQUE) |-> m_tdata[BEST_LSB +: SYM_W] == '0)
        else $error("best symbol set on a tie or unseen context");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind dna_order_k_context_counter_model_unit dkcm_checker u_dkcm_checker (.*);

[test/dna_order_k_context_counter_model_unit_tb.sv]
module dna_order_k_context_counter_model_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dkcm_pkg::*;

    // One row of the directed plan: either a register write or a symbol transfer.
    typedef struct packed {
        bit                    is_write;
        cfg_idx_t              reg_sel;
        logic [CFG_DATA_W-1:0] value;
        logic [SYM_W-1:0]      sym;
        logic                  restart;
        bit                    typed;
        result_t               want;
    } step_t;

    localparam int PLAN_LEN = 34;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the block: registers, rolling context and counter table.
    logic [ORDER_W-1:0]    k_order;
    logic [ALPHA_W-1:0]    alpha;
    logic [MAXC_W-1:0]     count_limit;
    logic [CTX_W-1:0]      history;
    bit [COUNT_WIDTH-1:0]  tally [NUM_CTX][4];

    result_t               pending_scores [$];
    int unsigned           error_count;
    int unsigned           send_idle;
    int unsigned           take_idle;
    step_t                 plan [PLAN_LEN];

    dna_order_k_context_counter_model_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Scores one symbol against the current context, then updates the counters
    // and shifts the symbol into the context.
    function automatic result_t score_symbol(input logic [SYM_W-1:0] sym,
                                             input logic restart);
        int unsigned     k;
        int unsigned     mask;
        int unsigned     ctx;
        int unsigned     top;
        int unsigned     nxt;
        int              n;
        longint unsigned f [4];
        longint unsigned sum;
        bit              tie;
        result_t         r;
        k = k_order;
        if (k < 1) k = 1;
        if (k > MAX_ORDER) k = MAX_ORDER;
        mask = (1 << (2 * k)) - 1;
        if (restart) history = '0;
        ctx = history & mask;

        sum = 0;
        for (n = 0; n < 4; n++) begin
            f[n] = 64'd1 + 64'(alpha) * 64'(tally[ctx][n]);
            sum += f[n];
            r.freq[n] = FREQ_W'(f[n]);
        end
        r.total = TOTAL_W'(sum);

        // The first largest frequency wins; any other equal to it is a tie.
        top = 0;
        tie = 1'b0;
        for (n = 1; n < 4; n++) begin
            if (f[n] > f[top]) top = n;
        end
        for (n = 0; n < 4; n++) begin
            if (n != top && f[n] == f[top]) tie = 1'b1;
        end
        if (sum == 4) begin
            r.best   = '0;
            r.status = STATUS_UNSEEN;
        end else if (tie) begin
            r.best   = '0;
            r.status = STATUS_TIE;
        end else begin
            r.best   = SYM_W'(top);
            r.status = STATUS_UNIQUE;
        end

        // Count update; reaching the limit or leaving the counter range halves the row.
        nxt = tally[ctx][sym] + 1;
        if (nxt >= count_limit || nxt > (1 << COUNT_WIDTH) - 1) begin
            for (n = 0; n < 4; n++) begin
                tally[ctx][n] = tally[ctx][n] >> 1;
            end
            tally[ctx][sym] = COUNT_WIDTH'(nxt >> 1);
        end else begin
            tally[ctx][sym] = COUNT_WIDTH'(nxt);
        end

        history = CTX_W'(((ctx << 2) | sym) & mask);
        return r;
    endfunction

    function automatic step_t item(input logic [SYM_W-1:0] sym, input logic restart);
        step_t s;
        s = '0;
        s.sym = sym;
        s.restart = restart;
        return s;
    endfunction

    // A symbol whose context has never been counted: every frequency is one.
    function automatic step_t fresh(input logic [SYM_W-1:0] sym, input logic restart);
        step_t s;
        s = item(sym, restart);
        s.typed = 1'b1;
        s.want.freq = {4{FREQ_W'(1)}};
        s.want.total = TOTAL_W'(4);
        s.want.best = '0;
        s.want.status = STATUS_UNSEEN;
        return s;
    endfunction

    function automatic step_t wr(input cfg_idx_t sel, input logic [CFG_DATA_W-1:0] value);
        step_t s;
        s = '0;
        s.is_write = 1'b1;
        s.reg_sel = sel;
        s.value = value;
        return s;
    endfunction

    // Stops the symbol stream and waits until every expected result is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t sel, input logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (sel)
            CFG_ORDER: k_order = value[ORDER_W-1:0];
            CFG_ALPHA: alpha = value[ALPHA_W-1:0];
            CFG_MAXC:  count_limit = value[MAXC_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sends one symbol; called and returning at a falling edge.
    task automatic push_symbol(input logic [SYM_W-1:0] sym, input logic restart,
                               input bit typed, input result_t want);
        result_t guess;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(sym);
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        guess = score_symbol(sym, restart);
        pending_scores.push_back(typed ? want : guess);
        @(negedge aclk);
    endtask

    // Receiver back-pressure.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= take_idle);
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = result_t'({m_tuser, m_tdata[4*FREQ_W+TOTAL_W+SYM_W-1:0]});
            if (pending_scores.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, seen);
                error_count++;
            end else begin
                want = pending_scores.pop_front();
                for (int n = 0; n < 4; n++) begin
                    if (seen.freq[n] !== want.freq[n]) begin
                        $display("%0t: freq[%0d] expected %0d, got %0d",
                                 $time, n, want.freq[n], seen.freq[n]);
                        error_count++;
                    end
                end
                if (seen.total !== want.total) begin
                    $display("%0t: freq_total expected %0d, got %0d",
                             $time, want.total, seen.total);
                    error_count++;
                end
                if (seen.best !== want.best) begin
                    $display("%0t: best_symbol expected %0d, got %0d",
                             $time, want.best, seen.best);
                    error_count++;
                end
                if (seen.status !== want.status) begin
                    $display("%0t: best_status expected %0d, got %0d",
                             $time, want.status, seen.status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int          phase;
        int          n;
        int          motif_len;
        int          pos;
        int unsigned pick;
        logic [1:0]  motif [5];
        logic [1:0]  sym;
        logic        restart;
        logic [3:0]  ord;
        logic [9:0]  a;
        logic [15:0] lim;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_ORDER;
        cfg_data    = '0;
        k_order     = ORDER_RESET;
        alpha       = ALPHA_RESET;
        count_limit = MAXC_RESET;
        history     = '0;
        error_count = 0;
        send_idle   = 29;
        take_idle   = 46;

        // Directed plan: extremes, ties, restarts and each odd register setting.
        plan = '{
            fresh(2'd0, 1'b1),          // first symbol after reset, table clear
            item(2'd0, 1'b0),
            item(2'd3, 1'b0),
            fresh(2'd3, 1'b0),          // context of a lone 3 not seen yet
            item(2'd3, 1'b1),
            item(2'd0, 1'b1),           // counts of 0 and 3 are equal here
            wr(CFG_ORDER, 16'h0000),    // order zero behaves as order one
            item(2'd1, 1'b0),
            item(2'd2, 1'b0),
            item(2'd1, 1'b0),
            wr(CFG_ORDER, 16'h000F),    // order above the maximum is clamped
            item(2'd2, 1'b0),
            item(2'd1, 1'b0),
            wr(CFG_ORDER, 16'hFFF3),    // upper data bits dropped, order three
            item(2'd0, 1'b0),
            item(2'd3, 1'b0),
            wr(CFG_ALPHA, 16'h0000),
            fresh(2'd0, 1'b1),          // zero alpha flattens every frequency
            fresh(2'd2, 1'b0),
            wr(CFG_ALPHA, 16'hFFFF),    // largest alpha
            wr(CFG_ORDER, 16'h0001),
            item(2'd0, 1'b1),
            item(2'd0, 1'b0),
            item(2'd0, 1'b0),
            wr(CFG_MAXC, 16'h0000),     // every update halves the row
            item(2'd0, 1'b0),
            item(2'd0, 1'b0),
            wr(CFG_MAXC, 16'h0002),
            item(2'd1, 1'b0),
            item(2'd1, 1'b0),
            item(2'd3, 1'b1),
            wr(CFG_MAXC, 16'hFFFF),
            wr(CFG_ALPHA, 16'h0001),
            wr(CFG_ORDER, 16'h0008)
        };

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                write_reg(plan[i].reg_sel, plan[i].value);
            end else begin
                push_symbol(plan[i].sym, plan[i].restart, plan[i].typed, plan[i].want);
            end
        end

        // Random phases, each with its own register settings and a repeating motif
        // so that contexts recur and counts climb into the halving range.
        for (phase = 0; phase < 12; phase++) begin
            if (phase < 4) begin
                send_idle = 29;
                take_idle = 46;
            end else if (phase < 8) begin
                send_idle = 46;
                take_idle = 29;
            end else begin
                send_idle = 0;
                take_idle = 0;
            end

            pick = $urandom_range(9);
            if (pick == 0) ord = 4'd0;
            else if (pick == 1) ord = 4'($urandom_range(15, 9));
            else if (pick == 2) ord = 4'd8;
            else ord = 4'($urandom_range(4, 1));
            write_reg(CFG_ORDER, {12'($urandom), ord});

            pick = $urandom_range(6);
            if (pick == 0) a = 10'd0;
            else if (pick == 1) a = 10'd1023;
            else if (pick == 2) a = 10'd1;
            else a = 10'($urandom_range(1023, 1));
            write_reg(CFG_ALPHA, {6'($urandom), a});

            pick = $urandom_range(7);
            if (pick == 0) lim = 16'd0;
            else if (pick == 1) lim = 16'd1;
            else if (pick == 2) lim = 16'hFFFF;
            else if (pick == 3) lim = 16'($urandom_range(65535, 2));
            else lim = 16'($urandom_range(12, 2));
            write_reg(CFG_MAXC, lim);

            motif_len = $urandom_range(5, 1);
            for (n = 0; n < 5; n++) motif[n] = 2'($urandom);
            pos = 0;

            for (n = 0; n < 108; n++) begin
                // Hold the stream until the pipeline and queue are empty.
                if (n == 54 && phase % 4 == 1) drain();
                if ($urandom_range(99) < 5) motif[$urandom_range(4)] = 2'($urandom);
                if ($urandom_range(99) < 70) begin
                    sym = motif[pos % motif_len];
                    pos++;
                end else begin
                    sym = 2'($urandom);
                end
                restart = ($urandom_range(99) < 3);
                push_symbol(sym, restart, 1'b0, '0);
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/dkcm_pkg.sv
rtl/core/dkcm_ram.sv
rtl/core/dna_order_k_context_counter_model_unit.sv
rtl/core/dkcm_checker.sv
test/dna_order_k_context_counter_model_unit_tb.sv
